### rtl/sbh_pkg.sv
// shared types, widths and helpers for the segment box hit test unit
package sbh_pkg;

  localparam int COORD_WIDTH = 20;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int CROSS_W     = PROD_W + 1;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [CROSS_W-1:0]     cross_t;

  typedef enum logic [1:0] {
    REG_MIN_X = 2'd0,
    REG_MAX_X = 2'd1,
    REG_MIN_Y = 2'd2,
    REG_MAX_Y = 2'd3
  } reg_idx_e;

  typedef struct packed {
    coord_t min_x;
    coord_t max_x;
    coord_t min_y;
    coord_t max_y;
  } box_t;

  // operands of one edge test, edge direction folded into len
  typedef struct packed {
    diff_t dseg;
    diff_t onorm;
    diff_t len;
    diff_t ox;
    diff_t oy;
  } edge_in_t;

  // parameter in [0,1] without dividing: num/den between 0 and 1
  function automatic logic in_range(input cross_t num, input cross_t den);
    logic pos;
    pos = !den[CROSS_W-1] && (den != '0);
    if (pos) begin
      in_range = !num[CROSS_W-1] && (num <= den);
    end else begin
      in_range = (num[CROSS_W-1] || (num == '0)) && (num >= den);
    end
  endfunction

endpackage

### rtl/sbh_regs.sv
// box window registers behind the apb port
module sbh_regs
  import sbh_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output box_t              box_o
);

  box_t     box_q, box_d;
  reg_idx_e idx;
  logic     wr_en;
  coord_t   wval;
  coord_t   rval;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign wval   = coord_t'(pwdata[COORD_WIDTH-1:0]);

  always_comb begin
    box_d = box_q;
    if (wr_en) begin
      unique case (idx)
        REG_MIN_X: box_d.min_x = wval;
        REG_MAX_X: box_d.max_x = wval;
        REG_MIN_Y: box_d.min_y = wval;
        REG_MAX_Y: box_d.max_y = wval;
        default:   box_d = box_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MIN_X: rval = box_q.min_x;
      REG_MAX_X: rval = box_q.max_x;
      REG_MIN_Y: rval = box_q.min_y;
      REG_MAX_Y: rval = box_q.max_y;
      default:   rval = '0;
    endcase
  end

  assign prdata = {{(DATA_W-COORD_WIDTH){rval[COORD_WIDTH-1]}}, rval};
  assign box_o  = box_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= '0;
    end else begin
      box_q <= box_d;
    end
  end

endmodule

### rtl/sbh_edge.sv
// crossing test of the segment against one box edge, two register stages
module sbh_edge
  import sbh_pkg::*;
(
  input  logic     clk_i,
  input  edge_in_t edge_i,
  input  diff_t    dxs_i,
  input  diff_t    dys_i,
  output logic     hit_o
);

  // products stage
  prod_t den_q, tn_q, p1_q, p2_q;
  prod_t den_d, tn_d, p1_d, p2_d;
  // numerator and t check stage
  cross_t un_q, un_d;
  cross_t den3_q, den3_d;
  logic   t_ok_q, t_ok_d;
  logic   nz_q, nz_d;

  assign den_d = edge_i.dseg * edge_i.len;
  assign tn_d  = edge_i.onorm * edge_i.len;
  assign p1_d  = edge_i.ox * dys_i;
  assign p2_d  = edge_i.oy * dxs_i;

  assign un_d   = cross_t'(p1_q) - cross_t'(p2_q);
  assign den3_d = cross_t'(den_q);
  assign t_ok_d = in_range(cross_t'(tn_q), cross_t'(den_q));
  assign nz_d   = (den_q != '0);

  always_ff @(posedge clk_i) begin
    den_q  <= den_d;
    tn_q   <= tn_d;
    p1_q   <= p1_d;
    p2_q   <= p2_d;
    un_q   <= un_d;
    den3_q <= den3_d;
    t_ok_q <= t_ok_d;
    nz_q   <= nz_d;
  end

  // parallel edges never count
  assign hit_o = nz_q && t_ok_q && in_range(un_q, den3_q);

endmodule

### rtl/segment_box_hit_test_unit.sv
// top level: segment against closed box hit test, four stage pipeline
//
//  channel   | handshake          | payload
//  ----------+--------------------+----------------------------------------
//  request   | start / busy       | start_x_i start_y_i end_x_i end_y_i
//  result    | done_o (strobe)    | hit_o
//  config    | apb psel/penable   | box_min_x box_max_x box_min_y box_max_y
//
// one request per cycle, each request gets its own result strobe
// the depth is set by the difference stage, the multiplier stage and the two wide compare stages
// busy stays low, results are strobed for one cycle and cannot be held off
// reset clears the valid bits and the box registers to zero
module segment_box_hit_test_unit
  import sbh_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  coord_t            start_x_i,
  input  coord_t            start_y_i,
  input  coord_t            end_x_i,
  input  coord_t            end_y_i,
  output logic              done_o,
  output logic              hit_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  box_t box;
  logic accept;

  sbh_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .box_o   (box)
  );

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 1: differences and endpoint inside test
  diff_t dxs_q, dys_q, ax_q, bx_q, ay_q, by_q, w_q, nw_q, h_q, nh_q;
  diff_t dxs_d, dys_d, ax_d, bx_d, ay_d, by_d, w_d, nw_d, h_d, nh_d;
  logic  in1_q, in1_d;
  logic  in0, in1;

  assign dxs_d = diff_t'(end_x_i) - diff_t'(start_x_i);
  assign dys_d = diff_t'(end_y_i) - diff_t'(start_y_i);
  assign ax_d  = diff_t'(box.min_x) - diff_t'(start_x_i);
  assign bx_d  = diff_t'(box.max_x) - diff_t'(start_x_i);
  assign ay_d  = diff_t'(box.min_y) - diff_t'(start_y_i);
  assign by_d  = diff_t'(box.max_y) - diff_t'(start_y_i);
  assign w_d   = diff_t'(box.max_x) - diff_t'(box.min_x);
  assign nw_d  = diff_t'(box.min_x) - diff_t'(box.max_x);
  assign h_d   = diff_t'(box.max_y) - diff_t'(box.min_y);
  assign nh_d  = diff_t'(box.min_y) - diff_t'(box.max_y);

  assign in0 = (start_x_i >= box.min_x) && (start_x_i <= box.max_x) &&
               (start_y_i >= box.min_y) && (start_y_i <= box.max_y);
  assign in1 = (end_x_i >= box.min_x) && (end_x_i <= box.max_x) &&
               (end_y_i >= box.min_y) && (end_y_i <= box.max_y);
  assign in1_d = in0 || in1;

  always_ff @(posedge clk_i) begin
    dxs_q <= dxs_d;
    dys_q <= dys_d;
    ax_q  <= ax_d;
    bx_q  <= bx_d;
    ay_q  <= ay_d;
    by_q  <= by_d;
    w_q   <= w_d;
    nw_q  <= nw_d;
    h_q   <= h_d;
    nh_q  <= nh_d;
    in1_q <= in1_d;
  end

  // edges in order bottom, right, top, left
  edge_in_t edge_in [4];
  logic     edge_hit [4];

  assign edge_in[0] = '{dseg: dys_q, onorm: ay_q, len: nw_q, ox: ax_q, oy: ay_q};
  assign edge_in[1] = '{dseg: dxs_q, onorm: bx_q, len: h_q,  ox: bx_q, oy: ay_q};
  assign edge_in[2] = '{dseg: dys_q, onorm: by_q, len: w_q,  ox: bx_q, oy: by_q};
  assign edge_in[3] = '{dseg: dxs_q, onorm: ax_q, len: nh_q, ox: ax_q, oy: by_q};

  for (genvar g = 0; g < 4; g++) begin : g_edge
    sbh_edge u_edge (
      .clk_i  (clk_i),
      .edge_i (edge_in[g]),
      .dxs_i  (dxs_q),
      .dys_i  (dys_q),
      .hit_o  (edge_hit[g])
    );
  end

  // inside flag rides along with the edge stages
  logic in2_q, in3_q;
  logic v1_q, v2_q, v3_q, v4_q;
  logic hit_q, hit_d;

  always_ff @(posedge clk_i) begin
    in2_q <= in1_q;
    in3_q <= in2_q;
  end

  assign hit_d = in3_q || edge_hit[0] || edge_hit[1] || edge_hit[2] || edge_hit[3];

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  assign done_o = v4_q;
  assign hit_o  = hit_q;

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 done_o)
    else $error("accepted request did not complete after four cycles");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |-> ##4 !done_o)
    else $error("result strobe without a matching request");

  a_inside_hits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && in1_q) |-> ##3 (done_o && hit_o))
    else $error("endpoint inside box but no hit reported");

endmodule
